[rtl/core/scg_pkg.sv]
// Shared types and constants for the scatter-gather coalescer.
`timescale 1ns / 1ps
package scg_pkg;

	localparam int PAGE_BITS  = 13;
	localparam int ADDR_W     = 64;
	localparam int LEN_W      = 32;
	localparam int PAGES_W    = 21;
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

	localparam logic [LEN_W-1:0]   OFFS_MASK = LEN_W'((64'd1 << PAGE_BITS) - 64'd1);
	localparam logic [LEN_W+1:0]   SPAN_MASK = (LEN_W + 2)'(OFFS_MASK);
	localparam logic [PAGES_W-1:0] PAGES_MAX = PAGES_W'(1 << 20);

	// one coalesced DMA entry
	typedef struct packed {
		logic [LEN_W-1:0]   offset;
		logic [LEN_W-1:0]   length;
		logic               final_flag;
		logic [PAGES_W-1:0] pages;
	} entry_t;

	// entries handed to the output queue in one cycle (0, 1 or 2)
	typedef struct packed {
		logic [1:0] cnt;
		entry_t     e0;
		entry_t     e1;
	} push_t;

endpackage

[rtl/core/scg_merge.sv]
// Segment input register, run state and merge logic.
`timescale 1ns / 1ps
module scg_merge (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [scg_pkg::ADDR_W-1:0] in_address,
	input  logic [scg_pkg::LEN_W-1:0]  in_length,
	input  logic                      in_last,
	input  logic                      space_ok,
	output scg_pkg::push_t            push
);
	import scg_pkg::*;

	logic                valid_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic [LEN_W-1:0]    len_s1;
	logic                last_s1;

	logic [ADDR_W-1:0]   prev_end_q;
	logic [LEN_W-1:0]    run_off_q;
	logic [LEN_W-1:0]    run_len_q;
	logic                in_list_q;

	logic                advance;
	logic                contig;
	logic                brk;
	logic [LEN_W-1:0]    run_end;
	logic [LEN_W-1:0]    rounded;
	logic [LEN_W-1:0]    new_off;
	logic [LEN_W-1:0]    new_len;
	logic [LEN_W+1:0]    span;
	logic [LEN_W+1:0]    page_raw;
	logic [PAGES_W-1:0]  pages;
	entry_t              brk_entry;
	entry_t              fin_entry;

	assign advance  = valid_s1 && space_ok;
	assign in_ready = !valid_s1 || space_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			addr_s1 <= in_address;
			len_s1  <= in_length;
			last_s1 <= in_last;
		end
	end

	always_comb begin
		contig  = (prev_end_q == addr_s1) ||
		          (((prev_end_q | addr_s1) & ADDR_W'(OFFS_MASK)) == '0);
		brk     = in_list_q && !contig;
		run_end = run_off_q + run_len_q;
		rounded = (run_end + OFFS_MASK) & ~OFFS_MASK;
		if (!in_list_q) begin
			new_off = addr_s1[LEN_W-1:0] & OFFS_MASK;
			new_len = len_s1;
		end else if (brk) begin
			new_off = rounded | (addr_s1[LEN_W-1:0] & OFFS_MASK);
			new_len = len_s1;
		end else begin
			new_off = run_off_q;
			new_len = run_len_q + len_s1;
		end
		// page span of the final run, no wrap, saturated
		span     = {2'b00, new_off} + {2'b00, new_len} + SPAN_MASK;
		page_raw = span >> PAGE_BITS;
		if (page_raw > (LEN_W + 2)'(PAGES_MAX)) begin
			pages = PAGES_MAX;
		end else begin
			pages = page_raw[PAGES_W-1:0];
		end
		brk_entry = '{offset: run_off_q, length: run_len_q, final_flag: 1'b0, pages: '0};
		fin_entry = '{offset: new_off, length: new_len, final_flag: 1'b1, pages: pages};

		push.cnt = 2'd0;
		push.e0  = brk ? brk_entry : fin_entry;
		push.e1  = fin_entry;
		if (advance) begin
			push.cnt = 2'({1'b0, brk} + {1'b0, last_s1});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_list_q <= 1'b0;
		end else if (advance) begin
			in_list_q <= !last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prev_end_q <= addr_s1 + ADDR_W'(len_s1);
			run_off_q  <= new_off;
			run_len_q  <= new_len;
		end
	end

endmodule

[rtl/core/scg_outq.sv]
// Four-entry result queue, up to two writes and one read per cycle.
`timescale 1ns / 1ps
module scg_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  scg_pkg::push_t  push,
	output logic            space_ok,
	output logic            out_valid,
	input  logic            out_ready,
	output scg_pkg::entry_t out_entry
);
	import scg_pkg::*;

	entry_t              mem [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_CNT_W-1:0]  count_q;
	logic                pop;
	logic [Q_PTR_W-1:0]  wr_ptr_nx;

	assign out_valid = (count_q != '0);
	assign out_entry = mem[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign space_ok  = (count_q <= Q_CNT_W'(Q_DEPTH - 2));
	assign wr_ptr_nx = wr_ptr_q + Q_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_ptr_q] <= push.e0;
		end
		if (push.cnt == 2'd2) begin
			mem[wr_ptr_nx] <= push.e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_PTR_W'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			count_q <= count_q + Q_CNT_W'(push.cnt) - Q_CNT_W'(pop);
		end
	end

endmodule

[rtl/core/scatter_gather_coalescer_unit.sv]
// Top level of the scatter-gather coalescer.
// Usage:
//  - Slave stream carries one scatter-gather segment per transaction:
//    tdata = {seg_length, seg_address}, tlast = last segment of the list.
//  - Master stream carries coalesced DMA entries: tdata = {pad, pages_needed,
//    entry_length, entry_offset}, tlast = final entry of the list.
//  - A segment joins the current run when it starts at the previous end or
//    when both sit on a page boundary; a break emits the finished entry, and
//    the last segment emits the final entry with its page count.
//  - Path: a segment is held in the input register, then its entries land
//    in the 4-entry output queue, whose head drives the master stream.
//  - Throughput: one segment per cycle while the output queue has room for
//    two entries. The master port moves one entry per cycle, so a segment
//    that produces two entries (break plus last) needs two transactions;
//    the output queue absorbs that.
//  - The input register advances only when the queue has room for two
//    entries, so a stalled receiver backs up into s_axis_tready after the
//    queue fills; nothing is dropped.
//  - Reset clears the input valid, the queue pointers and the in-list flag;
//    the next segment after reset starts a new list.
`timescale 1ns / 1ps
module scatter_gather_coalescer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // [63:0] seg_address, [95:64] seg_length
	input  logic        s_axis_tlast,  // last_segment
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata,  // [31:0] entry_offset, [63:32] entry_length,
	                                   // [84:64] pages_needed, [87:85] zero
	output logic        m_axis_tlast   // final_entry
);
	import scg_pkg::*;

	push_t  push;
	logic   space_ok;
	entry_t out_entry;

	scg_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_address (s_axis_tdata[63:0]),
		.in_length  (s_axis_tdata[95:64]),
		.in_last    (s_axis_tlast),
		.space_ok   (space_ok),
		.push       (push)
	);

	scg_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space_ok  (space_ok),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_entry (out_entry)
	);

	assign m_axis_tdata = {3'b000, out_entry.pages, out_entry.length, out_entry.offset};
	assign m_axis_tlast = out_entry.final_flag;

	// a segment yields at most two entries
	a_push_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != 2'd3)
		else $error("more than two entries pushed for one segment");

	// with two entries, the first is the broken run and the second is final
	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd2 |-> !push.e0.final_flag && push.e1.final_flag)
		else $error("two-entry push out of order");

	// entries only enter the queue when it had room for two
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != 2'd0 |-> space_ok)
		else $error("push without queue room");

	// non-final entries carry no page count
	a_pages_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[84:64] == '0)
		else $error("page count on a non-final entry");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the scatter-gather coalescer: segment lists in, DMA entries out.
`timescale 1ns / 1ps
module tb_top;
	import scg_pkg::*;

	// In-page offset mask at address width.
	localparam logic [63:0] PAGE_LOW  = (64'd1 << PAGE_BITS) - 64'd1;
	localparam int          PAGE_BYTES = 1 << PAGE_BITS;
	localparam int          RANDOM_SEGMENTS = 1750;

	// Scoreboard: tracks the coalescing state and holds the DMA entries still due.
	class coalesce_scoreboard;
		logic [63:0] seg_end;       // end address of the last segment seen
		logic [31:0] run_off;       // DMA offset of the open run
		logic [31:0] run_len;       // bytes gathered in the open run
		bit          list_open;     // a list is in progress
		entry_t      due_entries[$];
		int          errors;
		int          checked;
		int          breaks;
		int          double_entries;

		function new();
			list_open = 0;
			errors = 0;
			checked = 0;
			breaks = 0;
			double_entries = 0;
		endfunction

		// Accepted segment: advance the run and queue the entries it closes.
		function void note_segment(logic [63:0] addr, logic [31:0] len, logic is_last);
			logic [63:0] in_page;
			logic [31:0] run_end;
			logic [32:0] rounded_up;
			logic [63:0] span;
			entry_t      e;
			bit          joins;
			bit          broke;

			in_page = addr & PAGE_LOW;
			broke = 0;
			if (!list_open) begin
				run_off = in_page[31:0];
				run_len = len;
			end else begin
				joins = (seg_end == addr) || (((seg_end | addr) & PAGE_LOW) == 64'd0);
				if (!joins) begin
					e.offset = run_off;
					e.length = run_len;
					e.final_flag = 1'b0;
					e.pages = '0;
					due_entries.push_back(e);
					breaks++;
					broke = 1;
					// round the finished run up to a page; 32-bit wrap on the result
					run_end = run_off + run_len;
					rounded_up = {1'b0, run_end} + 33'(PAGE_LOW);
					rounded_up = rounded_up & ~33'(PAGE_LOW);
					run_off = rounded_up[31:0] + in_page[31:0];
					run_len = '0;
				end
				run_len = run_len + len;
			end
			seg_end = addr + 64'(len);

			if (is_last) begin
				span = 64'(run_off) + 64'(run_len) + PAGE_LOW;
				span = span >> PAGE_BITS;
				e.offset = run_off;
				e.length = run_len;
				e.final_flag = 1'b1;
				e.pages = (span > 64'(PAGES_MAX)) ? PAGES_MAX : span[PAGES_W-1:0];
				due_entries.push_back(e);
				if (broke)
					double_entries++;
				list_open = 0;
			end else begin
				list_open = 1;
			end
		endfunction

		// Accepted DMA entry: compare against the oldest one due.
		function void check_entry(logic [31:0] off, logic [31:0] len, logic fin,
				logic [PAGES_W-1:0] pages);
			entry_t e;

			checked++;
			if (due_entries.size() == 0) begin
				$display("%0t: unexpected entry off=%h len=%h final=%b pages=%0d",
					$time, off, len, fin, pages);
				errors++;
			end else begin
				e = due_entries.pop_front();
				if (off !== e.offset) begin
					$display("%0t: entry_offset exp %h got %h", $time, e.offset, off);
					errors++;
				end
				if (len !== e.length) begin
					$display("%0t: entry_length exp %h got %h", $time, e.length, len);
					errors++;
				end
				if (fin !== e.final_flag) begin
					$display("%0t: final_entry exp %b got %b", $time, e.final_flag, fin);
					errors++;
				end
				if (pages !== e.pages) begin
					$display("%0t: pages_needed exp %0d got %0d", $time, e.pages, pages);
					errors++;
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata;   // [63:0] seg_address, [95:64] seg_length
	logic        s_axis_tlast;   // last_segment
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [87:0] m_axis_tdata;   // [31:0] entry_offset, [63:32] entry_length,
	                             // [84:64] pages_needed, [87:85] zero
	logic        m_axis_tlast;   // final_entry

	coalesce_scoreboard sb = new();
	bit quiet;                   // suppresses idling on both sides
	int segments_sent;
	int lists_sent;

	scatter_gather_coalescer_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random backpressure, changed on the falling edge.
	always @(negedge clk) begin
		m_axis_tready <= quiet || ($urandom_range(99) >= 27);
	end

	// Every entry transaction is checked on the rising edge.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_entry(m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tlast,
				m_axis_tdata[84:64]);
	end

	// Drives one segment; entered and left at a falling edge. Random idle cycles
	// go in front, and tvalid stays high across back-to-back transactions.
	task automatic send_segment(input logic [63:0] addr, input logic [31:0] len,
			input logic is_last);
		while (!quiet && $urandom_range(99) < 27) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {len, addr};
		s_axis_tlast <= is_last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_segment(addr, len, is_last);
		segments_sent++;
		if (is_last)
			lists_sent++;
		@(negedge clk);
	endtask

	// Segment lengths: mostly small or whole pages (so ends land on page
	// boundaries), sometimes anything up to the full 32 bits.
	function automatic logic [31:0] pick_length();
		int r;

		r = $urandom_range(99);
		if (r < 30)
			return 32'($urandom_range(0, 300));
		else if (r < 55)
			return 32'(PAGE_BYTES * $urandom_range(0, 8));
		else if (r < 70)
			return 32'($urandom_range(0, 3 * PAGE_BYTES));
		else if (r < 88)
			return $urandom;
		else
			return 32'hFFFF_FFFF - 32'($urandom_range(0, PAGE_BYTES));
	endfunction

	// Addresses for a fresh run: full range, low region, near the top, aligned.
	function automatic logic [63:0] pick_address();
		int r;

		r = $urandom_range(99);
		if (r < 40)
			return {$urandom, $urandom};
		else if (r < 70)
			return {32'd0, $urandom};
		else if (r < 85)
			return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 4 * PAGE_BYTES));
		else
			return {$urandom, $urandom} & ~PAGE_LOW;
	endfunction

	initial begin
		logic [63:0] addr;
		logic [63:0] next_addr;
		logic [31:0] len;
		int          list_len;
		int          r;
		int          start_count;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		quiet = 0;
		segments_sent = 0;
		lists_sent = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed part ---
		// single zero-length segment, then all-ones extremes
		send_segment(64'd0, 32'd0, 1'b1);
		send_segment(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		// contiguous join, then break together with the last segment
		send_segment(64'h0000_1000_0000_1234, 32'd100, 1'b0);
		send_segment(64'h0000_1000_0000_1298, 32'd200, 1'b0);
		send_segment(64'h0000_2000_0000_0777, 32'd50, 1'b1);
		// page-aligned joins across gaps
		send_segment(64'h0000_0000_0000_4000, 32'h2000, 1'b0);
		send_segment(64'h0000_0000_0010_0000, 32'h4000, 1'b0);
		send_segment(64'h7FFF_FFFF_FFFF_E000, 32'h2000, 1'b1);
		// segment end wraps past the top of the address space
		send_segment(64'hFFFF_FFFF_FFFF_F000, 32'h1800, 1'b0);
		send_segment(64'h0000_0000_0000_0800, 32'd16, 1'b1);
		// page round-up of the next run wraps to zero
		send_segment(64'h0000_0000_0000_0100, 32'hFFFF_EF01, 1'b0);
		send_segment(64'h0000_0005_0000_0ABC, 32'd8, 1'b0);
		send_segment(64'h0000_0009_0000_0001, 32'hFFFF_FFFF, 1'b1);
		// run length wraps at 32 bits
		send_segment(64'h0000_0000_0000_1FFF, 32'hFFFF_FFFF, 1'b0);
		send_segment(64'h0000_0001_0000_1FFE, 32'hFFFF_FFFF, 1'b1);
		// page count at its top end
		send_segment(64'h0000_0000_0000_0000, 32'hFFFF_C000, 1'b0);
		send_segment(64'h0000_0003_0000_1FFF, 32'hFFFF_FFFF, 1'b1);
		// zero-length segments and a chain of breaks
		send_segment(64'h0000_0000_ABCD_0010, 32'd0, 1'b0);
		send_segment(64'h0000_0000_ABCD_0010, 32'd0, 1'b0);
		send_segment(64'h1234_5678_9ABC_DEF0, 32'h8000_0000, 1'b0);
		send_segment(64'h0000_0000_0000_0000, 32'd1, 1'b0);
		send_segment(64'h0000_0000_0000_2000, 32'd5, 1'b1);

		// --- random lists ---
		// Each follow-on segment is contiguous, an aligned jump, or a break.
		start_count = segments_sent;
		while (segments_sent - start_count < RANDOM_SEGMENTS) begin
			// a stretch in the middle runs with both sides always ready
			quiet = (segments_sent - start_count >= 700) &&
				(segments_sent - start_count < 1000);
			list_len = ($urandom_range(99) < 8) ? $urandom_range(16, 40) :
				$urandom_range(1, 8);
			addr = pick_address();
			for (int i = 0; i < list_len; i++) begin
				if (i > 0) begin
					r = $urandom_range(99);
					if (r < 45)
						addr = next_addr;
					else if (r < 65)
						addr = {$urandom, $urandom} & ~PAGE_LOW;
					else if (r < 75)
						addr = next_addr + 64'($urandom_range(1, 64));
					else
						addr = pick_address();
				end
				len = pick_length();
				next_addr = addr + 64'(len);
				send_segment(addr, len, i == list_len - 1);
			end
		end
		quiet = 0;
		s_axis_tvalid <= 1'b0;

		// drain, then keep the clock running so anything stray can still show up
		while (sb.due_entries.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("tb_top: %0d segments in %0d lists, %0d entries checked",
			segments_sent, lists_sent, sb.checked);
		$display("tb_top: %0d run breaks, %0d segments closing two entries at once",
			sb.breaks, sb.double_entries);
		if (sb.errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#3_000_000;
		$display("tb_top: timeout with %0d entries still due", sb.due_entries.size());
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
